@@ rtl/utf8_stream_validator_core_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_CORE_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define U8SV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8SV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define U8SV_ASSERT_IMP(lbl, ante, cons, msg)
`define U8SV_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/u8sv_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Shared types and byte-pattern constants for the validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sv_pkg;

    // Byte patterns used to classify lead and continuation bytes.
    localparam logic [7:0] ASCII_MAX      = 8'h7f;
    localparam logic [7:0] LEAD2_MASK     = 8'hE0;
    localparam logic [7:0] LEAD2_CODE     = 8'hC0;
    localparam logic [7:0] LEAD3_MASK     = 8'hF0;
    localparam logic [7:0] LEAD3_CODE     = 8'hE0;
    localparam logic [7:0] LEAD4_MASK     = 8'hF8;
    localparam logic [7:0] LEAD4_CODE     = 8'hF0;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_CODE      = 8'h80;
    localparam logic [7:0] ED_LEAD        = 8'hed;
    localparam logic [7:0] SURROGATE_BITS = 8'ha0;

    // Number of continuation bytes still owed by the current sequence.
    typedef logic [1:0] u8sv_count_t;

    localparam u8sv_count_t CONT_NONE  = 2'd0;
    localparam u8sv_count_t CONT_ONE   = 2'd1;
    localparam u8sv_count_t CONT_TWO   = 2'd2;
    localparam u8sv_count_t CONT_THREE = 2'd3;

    // Decoder state carried from byte to byte within one string.
    typedef struct packed {
        u8sv_count_t pending;
        logic        error_seen;
        logic        after_ed_lead;
    } u8sv_state_t;

    localparam u8sv_state_t STATE_CLEAR = '{
        pending:       CONT_NONE,
        error_seen:    1'b0,
        after_ed_lead: 1'b0
    };

    // One request as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } u8sv_item_t;

endpackage

`default_nettype wire

@@ rtl/u8sv_byte_step.sv @@
// ----------------------------------------------------------------------------
// UTF-8 byte step
// Computes the decoder state that follows one data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sv_byte_step
    import u8sv_pkg::*;
(
    input  wire u8sv_state_t cur_state,
    input  wire logic [7:0]  data_byte,
    output u8sv_state_t      next_state
);

    logic is_cont;
    logic is_surrogate;

    assign is_cont      = (data_byte & CONT_MASK) == CONT_CODE;
    assign is_surrogate = (data_byte & SURROGATE_BITS) == SURROGATE_BITS;

    always_comb
    begin
        next_state = cur_state;
        if (cur_state.error_seen)
        begin
            // Once broken, the string stays broken until its end marker.
            next_state = cur_state;
        end
        else if (cur_state.pending != CONT_NONE)
        begin
            next_state.after_ed_lead = 1'b0;
            if ((cur_state.after_ed_lead && is_surrogate) || !is_cont)
            begin
                next_state.error_seen = 1'b1;
            end
            else
            begin
                next_state.pending = cur_state.pending - CONT_ONE;
            end
        end
        else
        begin
            next_state.after_ed_lead = 1'b0;
            priority if (data_byte <= ASCII_MAX)
            begin
                next_state.pending = CONT_NONE;
            end
            else if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                next_state.pending = CONT_ONE;
            end
            else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                next_state.pending       = CONT_TWO;
                next_state.after_ed_lead = (data_byte == ED_LEAD);
            end
            else if ((data_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                next_state.pending = CONT_THREE;
            end
            else
            begin
                next_state.error_seen = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8sv_tracker.sv @@
// ----------------------------------------------------------------------------
// UTF-8 string tracker
// Holds the per-string decoder state and forms the verdict at the end marker.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_validator_core_macros.svh"

module u8sv_tracker
    import u8sv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire u8sv_item_t item,
    output logic            verdict
);

    u8sv_state_t state_reg;
    u8sv_state_t state_next;
    u8sv_state_t byte_state;

    u8sv_byte_step u_byte_step (
        .cur_state  (state_reg),
        .data_byte  (item.data_byte),
        .next_state (byte_state)
    );

    // The verdict reflects every byte that has already stepped through.
    assign verdict = !state_reg.error_seen && (state_reg.pending == CONT_NONE);

    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            state_next = item.end_marker ? STATE_CLEAR : byte_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `U8SV_ASSERT_NXT(a_end_clears, step && item.end_marker, state_reg == STATE_CLEAR,
        "tracker state not cleared after end marker")
    `U8SV_ASSERT_IMP(a_ed_needs_two, state_reg.after_ed_lead, state_reg.pending == CONT_TWO,
        "ED flag set without two pending continuations")
    `U8SV_ASSERT_NXT(a_error_sticks, state_reg.error_seen && step && !item.end_marker,
        state_reg.error_seen, "error cleared before end marker")

endmodule

`default_nettype wire

@@ rtl/utf8_stream_validator_core.sv @@
// Path: an accepted request is held in the input register, and the verdict of an end marker
// is then written to the result register, from which it is taken.
// Throughput: one request per cycle; only an end marker waiting on a stalled, full result
// register holds the input register and raises data_stall.
// Reset: rst_n clears the input and result valid flags and the decoder state at once,
// so the first string after reset starts empty.
// ----------------------------------------------------------------------------
// UTF-8 stream validator core
// Checks the UTF-8 structure of a byte stream and reports one verdict per string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_validator_core_macros.svh"

module utf8_stream_validator_core
    import u8sv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Byte channel: one data byte or one end marker per request.
    input  wire logic       data_valid,
    output logic            data_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_marker,
    // Result channel: one verdict per end marker.
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            is_valid
);

    // Input register. Each request lands here first and steps the decoder
    // from here; an end marker waits here while the result register is blocked.
    logic       in_valid_reg;
    logic       in_valid_next;
    u8sv_item_t in_item_reg;

    // Result register. It parts the decoder from the downstream stall, so
    // data bytes keep flowing while a verdict waits to be taken.
    logic result_valid_reg;
    logic result_valid_next;
    logic is_valid_reg;

    logic in_accept;
    logic out_free;
    logic step;
    logic verdict;

    // A data byte only updates the decoder state, so it always moves on.
    // An end marker needs room in the result register.
    assign out_free   = !result_valid_reg || !result_stall;
    assign step       = in_valid_reg && (!in_item_reg.end_marker || out_free);
    assign data_stall = in_valid_reg && !step;
    assign in_accept  = data_valid && !data_stall;

    u8sv_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (step && in_item_reg.end_marker)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.data_byte  <= data_byte;
            in_item_reg.end_marker <= end_marker;
        end
        if (step && in_item_reg.end_marker)
        begin
            is_valid_reg <= verdict;
        end
    end

    assign result_valid = result_valid_reg;
    assign is_valid     = is_valid_reg;

    `U8SV_ASSERT_IMP(a_stall_only_on_end, data_stall,
        in_valid_reg && in_item_reg.end_marker && result_valid_reg,
        "input stalled without a blocked end marker")
    `U8SV_ASSERT_NXT(a_end_gives_result, step && in_item_reg.end_marker, result_valid_reg,
        "end marker stepped without a result")
    `U8SV_ASSERT_NXT(a_byte_moves_on, in_valid_reg && !in_item_reg.end_marker && !in_accept,
        !in_valid_reg, "data byte held in the input register")

endmodule

`default_nettype wire
